// File: sv/framebuffer_point_plot_blend_unit_macros.svh
// ----------------------------------------------------------------------------
// framebuffer point plot/blend assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_POINT_PLOT_BLEND_UNIT_MACROS_SVH
`define FRAMEBUFFER_POINT_PLOT_BLEND_UNIT_MACROS_SVH

// same-cycle implication
`define FPPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fppb_pkg.sv
// ----------------------------------------------------------------------------
// fppb_pkg
// shared types, constants and helpers of the frame store plot/blend unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fppb_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int DIM_W    = 7;
  localparam int COORD_W  = 16;
  localparam int PIX_W    = 24;
  localparam int CHAN_W   = 8;
  localparam int CNT_W    = 16;
  localparam int ALPHA_W  = 9;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  // item actions
  localparam logic [1:0] ACT_FILL  = 2'd0;
  localparam logic [1:0] ACT_PLOT  = 2'd1;
  localparam logic [1:0] ACT_BLEND = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [ALPHA_W-1:0]        alpha;
    logic                      last_point;
  } point_item_t;

  typedef struct packed {
    logic              inside_res;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CNT_W-1:0]  drawn_count;
  } result_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BLEND,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic item_load;
    logic fill_init;
    logic fill_adv;
    logic mem_rd;
    logic mem_wr;
    logic wr_blend;
    logic use_fill_addr;
    logic out_load;
    logic out_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       pt_inside;
    logic       area_zero;
    logic       fill_last;
    logic       out_free;
  } dp_status_t;

  // clip a configured size to the store size
  function automatic logic [COORD_W-1:0] clip_dim(input logic [DIM_W-1:0] cfg,
                                                  input int max_dim);
    logic [COORD_W-1:0] lim;
    lim = COORD_W'(max_dim);
    return (COORD_W'(cfg) > lim) ? lim : COORD_W'(cfg);
  endfunction

  // (c*a + o*(256-a)) >> 8, sum never exceeds 255*256
  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] c,
                                                 input logic [CHAN_W-1:0] o,
                                                 input logic [ALPHA_W-1:0] a);
    logic [CHAN_W+ALPHA_W-1:0] s;
    s = (CHAN_W+ALPHA_W)'(c) * (CHAN_W+ALPHA_W)'(a)
      + (CHAN_W+ALPHA_W)'(o) * (CHAN_W+ALPHA_W)'(ALPHA_ONE - a);
    return s[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

`default_nettype wire

// File: sv/fppb_datapath.sv
// ----------------------------------------------------------------------------
// fppb_datapath
// frame store, clipping, fill walker, per-channel blend and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fppb_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  wire fppb_pkg::dp_cmd_t       cmd,
  output fppb_pkg::dp_status_t         status,
  input  wire fppb_pkg::point_item_t   point_data,
  input  wire [fppb_pkg::DIM_W-1:0]    width_cfg,
  input  wire [fppb_pkg::DIM_W-1:0]    height_cfg,
  input  wire [fppb_pkg::PIX_W-1:0]    color_cfg,
  output logic                         result_valid,
  input  wire                          result_stall,
  output fppb_pkg::result_item_t       result_data
);
  import fppb_pkg::*;

  logic [PIX_W-1:0]   frame_mem [FRAME_DEPTH];
  logic [PIX_W-1:0]   rd_data;
  point_item_t        item;
  point_item_t        item_next;
  logic [COL_W-1:0]   fill_x;
  logic [ROW_W-1:0]   fill_y;
  logic [CNT_W-1:0]   batch_count;
  logic [CNT_W-1:0]   count_next;
  logic [COORD_W-1:0] eff_w;
  logic [COORD_W-1:0] eff_h;
  logic [COORD_W-1:0] px_u;
  logic [COORD_W-1:0] py_u;
  logic [ADDR_W-1:0]  pt_addr;
  logic [ADDR_W-1:0]  fill_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [PIX_W-1:0]   blend_pix;
  logic [PIX_W-1:0]   wr_pix;
  logic               row_end;

  assign eff_w = clip_dim(width_cfg, MAX_WIDTH);
  assign eff_h = clip_dim(height_cfg, MAX_HEIGHT);
  assign px_u  = item.point_x;
  assign py_u  = item.point_y;

  assign pt_addr = ADDR_W'(ADDR_W'(py_u[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                 + ADDR_W'(px_u[COL_W-1:0]));
  assign fill_addr = ADDR_W'(ADDR_W'(fill_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(fill_x));
  assign wr_addr   = cmd.use_fill_addr ? fill_addr : pt_addr;

  assign blend_pix = {mix_chan(color_cfg[23:16], rd_data[23:16], item.alpha),
                      mix_chan(color_cfg[15:8],  rd_data[15:8],  item.alpha),
                      mix_chan(color_cfg[7:0],   rd_data[7:0],   item.alpha)};
  assign wr_pix = cmd.wr_blend ? blend_pix : color_cfg;

  assign row_end = (COORD_W'(fill_x) + COORD_W'(1)) == eff_w;

  assign status.action    = item.action;
  assign status.pt_inside = !px_u[COORD_W-1] && !py_u[COORD_W-1]
                            && (px_u < eff_w) && (py_u < eff_h);
  assign status.area_zero = (eff_w == '0) || (eff_h == '0);
  assign status.fill_last = row_end && ((COORD_W'(fill_y) + COORD_W'(1)) == eff_h);
  assign status.out_free  = !result_valid || !result_stall;

  assign count_next = (cmd.out_hit && batch_count != '1) ? batch_count + CNT_W'(1)
                                                         : batch_count;

  // alpha held already saturated
  always_comb begin
    item_next       = point_data;
    item_next.alpha = (point_data.alpha > ALPHA_ONE) ? ALPHA_ONE : point_data.alpha;
  end

  // item register
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item <= item_next;
    end
  end

  // fill walker, row-major over the active frame
  always_ff @(posedge clk) begin
    if (cmd.fill_init) begin
      fill_x <= '0;
      fill_y <= '0;
    end else if (cmd.fill_adv) begin
      if (row_end) begin
        fill_x <= '0;
        fill_y <= fill_y + ROW_W'(1);
      end else begin
        fill_x <= fill_x + COL_W'(1);
      end
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      frame_mem[wr_addr] <= wr_pix;
    end
    if (cmd.mem_rd) begin
      rd_data <= frame_mem[pt_addr];
    end
  end

  // result register and batch counter
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      batch_count  <= '0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
      batch_count  <= item.last_point ? '0 : count_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_data.inside_res  <= cmd.out_hit;
      result_data.red         <= cmd.out_hit ? wr_pix[23:16] : '0;
      result_data.green       <= cmd.out_hit ? wr_pix[15:8]  : '0;
      result_data.blue        <= cmd.out_hit ? wr_pix[7:0]   : '0;
      result_data.drawn_count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/fppb_ctrl.sv
// ----------------------------------------------------------------------------
// fppb_ctrl
// item sequencer: accept, execute, blend read-modify-write, fill sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_point_plot_blend_unit_macros.svh"

module fppb_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         point_valid,
  output logic                        point_stall,
  input  wire fppb_pkg::dp_status_t   status,
  output fppb_pkg::dp_cmd_t           cmd
);
  import fppb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (point_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (status.action == ACT_FILL) begin
          state_next = status.area_zero ? ST_RESP : ST_FILL;
        end else if (status.action == ACT_BLEND && status.pt_inside) begin
          state_next = ST_BLEND;
        end else begin
          state_next = status.out_free ? ST_IDLE : ST_EXEC;
        end
      end
      ST_BLEND: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_FILL: begin
        if (status.fill_last) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    point_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.item_load = point_valid;
      end
      ST_EXEC: begin
        priority if (status.action == ACT_FILL) begin
          cmd.fill_init = 1'b1;
        end else if (status.action == ACT_BLEND && status.pt_inside) begin
          cmd.mem_rd = 1'b1;
        end else begin
          // opaque plot, clipped point or unused action, once the result register is free
          cmd.out_load = status.out_free;
          cmd.out_hit  = status.out_free && (status.action == ACT_PLOT) && status.pt_inside;
          cmd.mem_wr   = status.out_free && (status.action == ACT_PLOT) && status.pt_inside;
        end
      end
      ST_BLEND: begin
        if (status.out_free) begin
          cmd.mem_wr   = 1'b1;
          cmd.wr_blend = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.mem_wr        = 1'b1;
        cmd.use_fill_addr = 1'b1;
        cmd.fill_adv      = 1'b1;
      end
      ST_RESP: begin
        cmd.out_load = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  `FPPB_ASSERT_IMP(a_load_free, cmd.out_load, status.out_free, "result loaded over a held beat")
  `FPPB_ASSERT_IMP(a_point_wr_result, cmd.mem_wr && !cmd.use_fill_addr,
                   cmd.out_load && cmd.out_hit, "point written without its result")
  `FPPB_ASSERT_NXT(a_fill_end, state == ST_FILL && status.fill_last, state == ST_RESP,
                   "fill sweep did not end on its last pixel")
  `FPPB_ASSERT_NXT(a_read_blend, cmd.mem_rd, state == ST_BLEND,
                   "pixel read not followed by blend")

endmodule

`default_nettype wire

// File: sv/framebuffer_point_plot_blend_unit.sv
// Opaque plot, clipped point or unused action: the item register, then the result register;
// composite goes through the registered frame store read, then blend and write back.
// Fill: one pixel written per cycle by the fill sweep, then the result beat.
// One item in flight: the next is taken once the current one has loaded its result;
// the result register lets the next item start while a beat waits.
// Synchronous reset clears the sequencer, result valid, batch count and the registers
// (64, 64, 0); the frame store keeps its contents.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// framebuffer_point_plot_blend_unit
// RGB888 frame store with fill, opaque point plot and alpha-composited point
// ----------------------------------------------------------------------------
module framebuffer_point_plot_blend_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            point_valid,
  output logic                           point_stall,
  input  wire fppb_pkg::point_item_t     point_data,
  output logic                           result_valid,
  input  wire                            result_stall,
  output fppb_pkg::result_item_t         result_data,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [fppb_pkg::APB_AW-1:0]     paddr,
  input  wire [fppb_pkg::APB_DW-1:0]     pwdata,
  output logic [fppb_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import fppb_pkg::*;

  logic [DIM_W-1:0] active_width;
  logic [DIM_W-1:0] active_height;
  logic [PIX_W-1:0] draw_color;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= DIM_W'(64);
      active_height <= DIM_W'(64);
      draw_color    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  active_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: active_height <= pwdata[DIM_W-1:0];
        REG_COLOR:  draw_color    <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = APB_DW'(active_width);
      REG_HEIGHT: prdata = APB_DW'(active_height);
      REG_COLOR:  prdata = APB_DW'(draw_color);
      default:    prdata = '0;
    endcase
  end

  fppb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .status      (status),
    .cmd         (cmd)
  );

  fppb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .point_data   (point_data),
    .width_cfg    (active_width),
    .height_cfg   (active_height),
    .color_cfg    (draw_color),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

`default_nettype wire
